FILE: src/jsu_pkg.sv
package jsu_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_END    = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_INTERP = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [1:0]       cnt_m1;
    logic [3:0][7:0]  bytes;
  } burst_t;

  function automatic burst_t single_result(input kind_t kind, input logic [7:0] b);
    burst_t r;
    r          = '0;
    r.kind     = kind;
    r.cnt_m1   = 2'd0;
    r.bytes[0] = b;
    return r;
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic burst_t utf8_encode(input logic [20:0] cp);
    burst_t r;
    r      = '0;
    r.kind = KIND_DATA;
    if (cp < 21'h80) begin
      r.cnt_m1   = 2'd0;
      r.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      r.cnt_m1   = 2'd1;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.cnt_m1   = 2'd2;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt_m1   = 2'd3;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

FILE: src/jsu_front.sv
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [7:0]       byte_in,
  input  logic             eos,
  output logic             emit,
  output jsu_pkg::burst_t  emit_burst
);
  import jsu_pkg::*;

  typedef enum logic [5:0] {
    PH_READY     = 6'b000001,
    PH_ESCAPE    = 6'b000010,
    PH_HEX_FIRST = 6'b000100,
    PH_WANT_BSL  = 6'b001000,
    PH_WANT_U    = 6'b010000,
    PH_HEX_LOW   = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hi_r, hi_nxt;

  logic [4:0]  hd;
  logic [15:0] acc_sh;
  logic        is_high, is_low;
  logic [10:0] plane;

  assign hd      = hex_digit(byte_in);
  assign acc_sh  = {acc_r[11:0], hd[3:0]};
  assign is_high = (acc_sh[15:10] == 6'b110110);
  assign is_low  = (acc_sh[15:10] == 6'b110111);
  assign plane   = 11'({1'b0, hi_r}) + 11'h040;

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    hi_nxt     = hi_r;
    emit       = 1'b0;
    emit_burst = single_result(KIND_DATA, byte_in);
    if (eos) begin
      phase_nxt  = PH_READY;
      acc_nxt    = '0;
      cnt_nxt    = '0;
      hi_nxt     = '0;
      emit       = 1'b1;
      emit_burst = single_result(KIND_ERROR, 8'h00);
    end else begin
      case (phase_r)
        PH_ESCAPE: begin
          phase_nxt = PH_READY;
          emit      = 1'b1;
          case (byte_in)
            8'h22:   emit_burst = single_result(KIND_DATA, 8'h22);
            8'h5C:   emit_burst = single_result(KIND_DATA, 8'h5C);
            8'h2F:   emit_burst = single_result(KIND_DATA, 8'h2F);
            8'h62:   emit_burst = single_result(KIND_DATA, 8'h08);
            8'h66:   emit_burst = single_result(KIND_DATA, 8'h0C);
            8'h6E:   emit_burst = single_result(KIND_DATA, 8'h0A);
            8'h72:   emit_burst = single_result(KIND_DATA, 8'h0D);
            8'h74:   emit_burst = single_result(KIND_DATA, 8'h09);
            8'h75: begin
              emit      = 1'b0;
              phase_nxt = PH_HEX_FIRST;
              acc_nxt   = '0;
              cnt_nxt   = '0;
            end
            8'h28: begin
              acc_nxt    = '0;
              cnt_nxt    = '0;
              hi_nxt     = '0;
              emit_burst = single_result(KIND_INTERP, 8'h00);
            end
            default: begin
              acc_nxt    = '0;
              cnt_nxt    = '0;
              hi_nxt     = '0;
              emit_burst = single_result(KIND_ERROR, 8'h00);
            end
          endcase
        end
        PH_HEX_FIRST, PH_HEX_LOW: begin
          if (!hd[4]) begin
            phase_nxt  = PH_READY;
            acc_nxt    = '0;
            cnt_nxt    = '0;
            hi_nxt     = '0;
            emit       = 1'b1;
            emit_burst = single_result(KIND_ERROR, 8'h00);
          end else if (cnt_r != 2'd3) begin
            acc_nxt = acc_sh;
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (phase_r == PH_HEX_FIRST) begin
              if (is_high) begin
                hi_nxt    = acc_sh[9:0];
                phase_nxt = PH_WANT_BSL;
              end else begin
                phase_nxt  = PH_READY;
                emit       = 1'b1;
                emit_burst = utf8_encode(is_low ? 21'h00FFFD : {5'd0, acc_sh});
              end
            end else begin
              phase_nxt = PH_READY;
              hi_nxt    = '0;
              emit      = 1'b1;
              if (is_low) begin
                emit_burst = utf8_encode({plane, acc_sh[9:0]});
              end else begin
                emit_burst = single_result(KIND_ERROR, 8'h00);
              end
            end
          end
        end
        PH_WANT_BSL: begin
          if (byte_in == 8'h5C) begin
            phase_nxt = PH_WANT_U;
          end else begin
            phase_nxt  = PH_READY;
            hi_nxt     = '0;
            emit       = 1'b1;
            emit_burst = single_result(KIND_ERROR, 8'h00);
          end
        end
        PH_WANT_U: begin
          if (byte_in == 8'h75) begin
            phase_nxt = PH_HEX_LOW;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end else begin
            phase_nxt  = PH_READY;
            hi_nxt     = '0;
            emit       = 1'b1;
            emit_burst = single_result(KIND_ERROR, 8'h00);
          end
        end
        default: begin
          phase_nxt = PH_READY;
          if (byte_in == 8'h22) begin
            acc_nxt    = '0;
            cnt_nxt    = '0;
            hi_nxt     = '0;
            emit       = 1'b1;
            emit_burst = single_result(KIND_END, 8'h00);
          end else if (byte_in == 8'h5C) begin
            phase_nxt = PH_ESCAPE;
          end else begin
            emit       = 1'b1;
            emit_burst = single_result(KIND_DATA, byte_in);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_READY;
      acc_r   <= '0;
      cnt_r   <= '0;
      hi_r    <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

FILE: src/jsu_queue.sv
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jsu_pkg::burst_t  push_data,
  output logic             full,
  input  logic             pop,
  output jsu_pkg::burst_t  head,
  output logic             empty
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  burst_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: src/jsu_back.sv
module jsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jsu_pkg::burst_t  head,
  input  logic             empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import jsu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign out_tvalid = !empty;
  assign out_tdata  = head.bytes[idx_r];
  assign out_tuser  = head.kind;
  assign out_tlast  = (idx_r == head.cnt_m1);
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && out_tlast;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = out_tlast ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

FILE: src/json_string_unescape_to_utf8.sv
// Results are queued on their input transaction and offered from the queue head.
// One input byte is taken per cycle unless the queue is full; the output drains one
// UTF-8 byte per cycle while out_tready is high, so a 2 to 4 byte \u result holds
// the output while a queue of QUEUE_DEPTH results keeps input flowing until full.
// Reset: synchronous, active low; clears decoder phase, hex state and queue pointers.
module json_string_unescape_to_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tuser,   // [0] end_of_source
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);
  import jsu_pkg::*;

  logic   in_fire;
  logic   emit;
  burst_t emit_burst;
  logic   q_full, q_empty, q_pop;
  burst_t q_head;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .byte_in    (in_tdata),
    .eos        (in_tuser),
    .emit       (emit),
    .emit_burst (emit_burst)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && emit),
    .push_data (emit_burst),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LPAREN = 8'h28;

  localparam logic [15:0] HIGH_MIN    = 16'hD800;
  localparam logic [15:0] HIGH_MAX    = 16'hDBFF;
  localparam logic [15:0] LOW_MIN     = 16'hDC00;
  localparam logic [15:0] LOW_MAX     = 16'hDFFF;
  localparam logic [15:0] REPLACEMENT = 16'hFFFD;

  typedef enum {
    DEC_PLAIN,
    DEC_ESCAPE,
    DEC_HEX,
    DEC_WANT_BSL,
    DEC_WANT_U,
    DEC_HEX_LOW
  } dec_phase_t;

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  typedef struct {
    logic [7:0] b;
    logic       eos;
  } src_item_t;

  function automatic int nib(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // {hit, decoded byte} for the single-character escapes
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    case (c)
      CH_QUOTE: return {1'b1, CH_QUOTE};
      CH_BSL:   return {1'b1, CH_BSL};
      "/":      return {1'b1, 8'h2F};
      "b":      return {1'b1, 8'h08};
      "f":      return {1'b1, 8'h0C};
      "n":      return {1'b1, 8'h0A};
      "r":      return {1'b1, 8'h0D};
      "t":      return {1'b1, 8'h09};
      default:  return 9'h000;
    endcase
  endfunction

  function automatic logic [7:0] esc_letter(input int i);
    case (i)
      0:       return CH_QUOTE;
      1:       return CH_BSL;
      2:       return "/";
      3:       return "b";
      4:       return "f";
      5:       return "n";
      6:       return "r";
      default: return "t";
    endcase
  endfunction

  class unescape_board;
    result_t     pending[$];
    result_t     burst[$];
    dec_phase_t  ph;
    logic [15:0] acc;
    int          ndig;
    logic [15:0] high_half;
    int          errors;
    int          n_in;
    int          n_out;
    int          kinds_seen[4];

    function new();
      reset_state();
      errors = 0;
      n_in   = 0;
      n_out  = 0;
      foreach (kinds_seen[i]) kinds_seen[i] = 0;
    endfunction

    function void reset_state();
      ph        = DEC_PLAIN;
      acc       = '0;
      ndig      = 0;
      high_half = '0;
    endfunction

    function void emit(input logic [7:0] b, input kind_t k);
      result_t r;
      r.data = b;
      r.kind = k;
      r.last = 1'b0;
      burst.insert(burst.size(), r);
    endfunction

    function void close_with(input kind_t k);
      reset_state();
      emit(8'h00, k);
    endfunction

    function void emit_cp(input logic [20:0] cp);
      if (cp < 21'h80) begin
        emit({1'b0, cp[6:0]}, KIND_DATA);
      end else if (cp < 21'h800) begin
        emit(8'hC0 | 8'(cp >> 6), KIND_DATA);
        emit(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
      end else if (cp < 21'h10000) begin
        emit(8'hE0 | 8'(cp >> 12), KIND_DATA);
        emit(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
        emit(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
      end else begin
        emit(8'hF0 | 8'((cp >> 18) & 21'h07), KIND_DATA);
        emit(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA);
        emit(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
        emit(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
      end
    endfunction

    function void note_input(input logic [7:0] c, input logic eos);
      int          d;
      logic [8:0]  esc;
      logic [15:0] v;
      logic [20:0] cp;
      burst.delete();
      n_in++;
      if (eos) begin
        close_with(KIND_ERROR);
      end else begin
        case (ph)
          DEC_ESCAPE: begin
            esc = simple_escape(c);
            if (esc[8]) begin
              ph = DEC_PLAIN;
              emit(esc[7:0], KIND_DATA);
            end else if (c == CH_U) begin
              ph   = DEC_HEX;
              acc  = '0;
              ndig = 0;
            end else if (c == CH_LPAREN) begin
              close_with(KIND_INTERP);
            end else begin
              close_with(KIND_ERROR);
            end
          end
          DEC_HEX, DEC_HEX_LOW: begin
            d = nib(c);
            if (d < 0) begin
              close_with(KIND_ERROR);
            end else begin
              acc = {acc[11:0], 4'(d)};
              if (ndig < 3) begin
                ndig++;
              end else begin
                v    = acc;
                ndig = 0;
                acc  = '0;
                if (ph == DEC_HEX) begin
                  if (v >= HIGH_MIN && v <= HIGH_MAX) begin
                    high_half = v;
                    ph        = DEC_WANT_BSL;
                  end else begin
                    if (v >= LOW_MIN && v <= LOW_MAX) v = REPLACEMENT;
                    ph = DEC_PLAIN;
                    emit_cp({5'd0, v});
                  end
                end else if (v >= LOW_MIN && v <= LOW_MAX) begin
                  cp = 21'h10000 + (21'(high_half - HIGH_MIN) << 10) + 21'(v - LOW_MIN);
                  reset_state();
                  emit_cp(cp);
                end else begin
                  close_with(KIND_ERROR);
                end
              end
            end
          end
          DEC_WANT_BSL: begin
            if (c == CH_BSL) ph = DEC_WANT_U;
            else close_with(KIND_ERROR);
          end
          DEC_WANT_U: begin
            if (c == CH_U) begin
              ph   = DEC_HEX_LOW;
              acc  = '0;
              ndig = 0;
            end else begin
              close_with(KIND_ERROR);
            end
          end
          default: begin
            ph = DEC_PLAIN;
            if (c == CH_QUOTE) close_with(KIND_END);
            else if (c == CH_BSL) ph = DEC_ESCAPE;
            else emit(c, KIND_DATA);
          end
        endcase
      end
      if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending.insert(pending.size(), burst[i]);
    endfunction

    function void check_result(input logic [7:0] b, input kind_t k, input logic l);
      result_t e;
      n_out++;
      kinds_seen[int'(k)]++;
      if (pending.size() == 0) begin
        $error("unexpected result: out_byte %02h kind %0d last %0b", b, k, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (b !== e.data) begin
        $error("out_byte: expected %02h, got %02h", e.data, b);
        errors++;
      end
      if (k !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, k);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  unescape_board sb;
  src_item_t     src_q[$];
  logic [7:0]    tok[$];
  int            rdy_wait;
  int            cyc;
  string         seed_s;

  json_string_unescape_to_utf8 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // output backpressure: calm stretches, short stalls, rare long stalls
  always @(posedge clk) begin
    cyc++;
    if (rdy_wait > 0) begin
      rdy_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ((cyc / 300) % 3 != 0) begin
        case ($urandom_range(0, 99)) inside
          [0:2]:   rdy_wait = $urandom_range(15, 50);
          [3:22]:  rdy_wait = $urandom_range(1, 3);
          default: rdy_wait = 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, kind_t'(out_tuser), out_tlast);
    end
  end

  function automatic void put_byte(input logic [7:0] b);
    tok.insert(tok.size(), b);
  endfunction

  function automatic void put_hex4(input logic [15:0] v);
    logic [3:0] n;
    for (int i = 3; i >= 0; i--) begin
      n = v[4*i +: 4];
      if (n < 10) put_byte(8'("0") + 8'(n));
      else if ($urandom_range(0, 1) != 0) put_byte(8'("A") + 8'(n) - 8'd10);
      else put_byte(8'("a") + 8'(n) - 8'd10);
    end
  endfunction

  function automatic void put_u(input logic [15:0] v);
    put_byte(CH_BSL);
    put_byte(CH_U);
    put_hex4(v);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (nib(b) >= 0);
    return b;
  endfunction

  function automatic logic [15:0] single_unit();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      1, 2:    return 16'($urandom_range(0, 'h7F));
      3, 4:    return 16'($urandom_range('h80, 'h7FF));
      5, 6:    return 16'($urandom_range('h800, 'hD7FF));
      7:       return 16'($urandom_range('hE000, 'hFFFF));
      default: return 16'($urandom_range(LOW_MIN, LOW_MAX));
    endcase
  endfunction

  function automatic void put_eos();
    src_item_t s;
    s.b   = 8'($urandom_range(0, 255));
    s.eos = 1'b1;
    src_q.insert(src_q.size(), s);
  endfunction

  function automatic void commit();
    src_item_t s;
    foreach (tok[i]) begin
      s.b   = tok[i];
      s.eos = 1'b0;
      src_q.insert(src_q.size(), s);
    end
    tok.delete();
  endfunction

  function automatic void add_token();
    int          r;
    int          n;
    logic [15:0] v;
    logic [7:0]  b;
    tok.delete();
    r = $urandom_range(0, 99);
    if (r < 35) begin
      put_byte(8'($urandom_range(0, 255)));
    end else if (r < 50) begin
      put_byte(CH_BSL);
      put_byte(esc_letter($urandom_range(0, 7)));
    end else if (r < 65) begin
      put_u(single_unit());
    end else if (r < 75) begin
      put_u(16'($urandom_range(HIGH_MIN, HIGH_MAX)));
      put_u(16'($urandom_range(LOW_MIN, LOW_MAX)));
    end else if (r < 80) begin
      put_u(16'($urandom_range(HIGH_MIN, HIGH_MAX)));
      case ($urandom_range(0, 3))
        0: begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_BSL);
          put_byte(b);
        end
        1: begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_U);
          put_byte(CH_BSL);
          put_byte(b);
        end
        2: begin
          do v = 16'($urandom_range(0, 'hFFFF)); while (v >= LOW_MIN && v <= LOW_MAX);
          put_u(v);
        end
        default: begin
          put_byte(CH_BSL);
          put_byte(CH_U);
          put_byte("d");
          put_byte("C");
          put_byte(non_hex());
        end
      endcase
    end else if (r < 84) begin
      do b = 8'($urandom_range(0, 255));
      while (simple_escape(b) != 0 || b == CH_U || b == CH_LPAREN);
      put_byte(CH_BSL);
      put_byte(b);
    end else if (r < 88) begin
      put_byte(CH_BSL);
      put_byte(CH_U);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) put_byte("0" + 8'($urandom_range(0, 9)));
      put_byte(non_hex());
    end else if (r < 91) begin
      put_byte(CH_BSL);
      put_byte(CH_LPAREN);
    end else if (r < 96) begin
      put_byte(CH_QUOTE);
    end else begin
      put_eos();
      return;
    end
    // cut the sequence short and end the source in the middle of it
    if (tok.size() > 1 && $urandom_range(0, 99) < 6) begin
      n = $urandom_range(1, tok.size() - 1);
      while (tok.size() > n) void'(tok.pop_back());
      commit();
      put_eos();
    end else begin
      commit();
    end
  endfunction

  task automatic idle_gap(input int idx);
    int n;
    n = 0;
    if ((idx / 60) % 3 != 0) begin
      case ($urandom_range(0, 99)) inside
        [0:4]:   n = $urandom_range(10, 40);
        [5:29]:  n = $urandom_range(1, 3);
        default: n = 0;
      endcase
    end
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(input src_item_t s);
    in_tvalid <= 1'b1;
    in_tdata  <= s.b;
    in_tuser  <= s.eos;
    do @(posedge clk); while (!in_tready);
    sb.note_input(s.b, s.eos);
  endtask

  task automatic drive_all();
    foreach (src_q[i]) begin
      idle_gap(i);
      send_item(src_q[i]);
    end
    in_tvalid <= 1'b0;
    src_q.delete();
  endtask

  task automatic drain();
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    rdy_wait   = 0;
    cyc        = 0;
    sb         = new();

    put_byte(8'h00);
    put_byte(8'hFF);
    seed_s = "\\n\\uD83D\\uDE00\\udc00\\(\"";
    for (int i = 0; i < seed_s.len(); i++) begin
      put_byte(seed_s[i]);
    end
    commit();
    put_eos();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    drive_all();
    drain();
    repeat (2) begin
      while (src_q.size() < 200) add_token();
      drive_all();
      drain();
    end
    repeat (10) @(posedge clk);

    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("covered %0d input transactions, %0d results checked", sb.n_in, sb.n_out);
    $display("  data %0d, closed %0d, syntax error %0d, interpolation %0d",
             sb.kinds_seen[0], sb.kinds_seen[1], sb.kinds_seen[2], sb.kinds_seen[3]);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_to_utf8.sv
dv/tb.sv
